### hdl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, widths, constants and the arctangent table for the laser
// scan to point converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

    localparam int MAX_EXTENSIONS = 63;
    localparam int TRIG_FRAC_BITS = 15;

    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int RAY_W    = 14;
    localparam int COORD_W  = 18;
    localparam int TRIG_W   = TRIG_FRAC_BITS + 1;
    localparam int EXT_W    = 6;
    localparam int OFF_W    = 20;
    localparam int DIST_W   = 21;
    localparam int PROD_W   = DIST_W + 1 + TRIG_W;

    localparam int CORDIC_W     = 32;
    localparam int Z_W          = 24;
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = 4;
    localparam int CORDIC_Q     = 30;
    localparam int TRIG_SH      = CORDIC_Q - TRIG_FRAC_BITS;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ANGLE = 3'd0,
        CFG_ANGLE_STEP  = 3'd1,
        CFG_MIN_RANGE   = 3'd2,
        CFG_MAX_RANGE   = 3'd3,
        CFG_RAY_STEP    = 3'd4,
        CFG_RAY_LENGTH  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] angle_step;
        logic [RANGE_W-1:0] min_range;
        logic [RANGE_W-1:0] max_range;
        logic [RAY_W-1:0]   ray_step;
        logic [RAY_W-1:0]   ray_length;
    } t_cfg;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0] range;
    } t_beam;

    typedef struct packed {
        logic          full;
        logic          empty;
        logic [Q_AW:0] count;
    } t_q_stat;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            4'd0:    v = 24'sd2097152;
            4'd1:    v = 24'sd1238021;
            4'd2:    v = 24'sd654136;
            4'd3:    v = 24'sd332050;
            4'd4:    v = 24'sd166669;
            4'd5:    v = 24'sd83416;
            4'd6:    v = 24'sd41718;
            4'd7:    v = 24'sd20860;
            4'd8:    v = 24'sd10430;
            4'd9:    v = 24'sd5215;
            4'd10:   v = 24'sd2608;
            4'd11:   v = 24'sd1304;
            4'd12:   v = 24'sd652;
            4'd13:   v = 24'sd326;
            4'd14:   v = 24'sd163;
            default: v = 24'sd81;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/lsp_front.sv
// ----------------------------------------------------------------------------
// lsp_front
// Intake side: tracks the beam angle, checks the range window and queues
// in-window beams for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lsp_pkg::t_cfg                i_cfg,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [lsp_pkg::RANGE_W-1:0]  i_s_axis_tdata,  // [15:0] range_mm
    input  wire logic                         i_s_axis_tuser,  // [0] scan_start
    input  wire lsp_pkg::t_q_stat             i_q_stat,
    output logic                              o_push,
    output lsp_pkg::t_beam                    o_push_data,
    output logic [lsp_pkg::ANGLE_W-1:0]       o_angle
);
    import lsp_pkg::*;

    logic [ANGLE_W-1:0] r_angle;
    logic [ANGLE_W-1:0] n_angle;
    logic               w_acc;
    logic               w_in_win;

    assign o_s_axis_tready = !i_q_stat.full;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign n_angle         = i_s_axis_tuser ? i_cfg.start_angle
                                            : r_angle + i_cfg.angle_step;
    assign w_in_win        = (i_s_axis_tdata > i_cfg.min_range) &&
                             (i_s_axis_tdata < i_cfg.max_range);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (w_acc) begin
            r_angle <= n_angle;
        end
    end

    assign o_push            = w_acc && w_in_win;
    assign o_push_data.angle = n_angle;
    assign o_push_data.range = i_s_axis_tdata;
    assign o_angle           = r_angle;

endmodule

`default_nettype wire

### hdl/lsp_queue.sv
// ----------------------------------------------------------------------------
// lsp_queue
// Short first-in first-out buffer of beams between intake and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lsp_pkg::t_beam   i_push_data,
    input  wire logic             i_pop,
    output lsp_pkg::t_beam        o_pop_data,
    output lsp_pkg::t_q_stat      o_stat
);
    import lsp_pkg::*;

    t_beam           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_pop_data   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/lsp_back.sv
// ----------------------------------------------------------------------------
// lsp_back
// Back end: iterative CORDIC for the beam angle, then emits the hit point
// and its ray extensions through a multiply stage and an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lsp_pkg::t_cfg                 i_cfg,
    input  wire lsp_pkg::t_q_stat              i_q_stat,
    input  wire lsp_pkg::t_beam                i_beam,
    output logic                               o_pop,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [2*lsp_pkg::COORD_W+3:0]      o_m_axis_tdata,  // [17:0] x_mm, [35:18] y_mm
    output logic                               o_m_axis_tuser,  // [0] is_extension
    output logic                               o_m_axis_tlast   // last_of_beam
);
    import lsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROT  = 4'b0010,
        S_FIN  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    localparam logic signed [CORDIC_W:0] TRIG_RND = (CORDIC_W+1)'(2**(TRIG_SH-1));
    localparam logic signed [CORDIC_W:0] TRIG_HI  = (CORDIC_W+1)'(2**TRIG_FRAC_BITS - 1);
    localparam logic signed [CORDIC_W:0] TRIG_LO  = -TRIG_HI - 1;
    localparam logic signed [PROD_W:0]   CRD_RND  = (PROD_W+1)'(2**(TRIG_FRAC_BITS-1));
    localparam logic signed [PROD_W:0]   CRD_HI   = (PROD_W+1)'(2**(COORD_W-1) - 1);
    localparam logic signed [PROD_W:0]   CRD_LO   = -CRD_HI - 1;

    function automatic logic signed [TRIG_W-1:0] round_trig(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W:0] s;
        logic signed [CORDIC_W:0] r;
        s = (CORDIC_W+1)'(v) + TRIG_RND;
        r = s >>> TRIG_SH;
        if (r > TRIG_HI) begin
            r = TRIG_HI;
        end else if (r < TRIG_LO) begin
            r = TRIG_LO;
        end
        return r[TRIG_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] to_coord(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] s;
        logic signed [PROD_W:0] r;
        s = (PROD_W+1)'(p) + CRD_RND;
        r = s >>> TRIG_FRAC_BITS;
        if (r > CRD_HI) begin
            r = CRD_HI;
        end else if (r < CRD_LO) begin
            r = CRD_LO;
        end
        return r[COORD_W-1:0];
    endfunction

    t_state                    r_state;
    logic [ITER_W-1:0]         r_iter;
    logic [1:0]                r_quad;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [Z_W-1:0]     r_z;
    logic [RANGE_W-1:0]        r_range;
    logic signed [TRIG_W-1:0]  r_cos;
    logic signed [TRIG_W-1:0]  r_sin;
    logic [EXT_W-1:0]          r_k;
    logic [OFF_W-1:0]          r_off;

    logic                      r_mv;
    logic signed [PROD_W-1:0]  r_px;
    logic signed [PROD_W-1:0]  r_py;
    logic                      r_m_ext;
    logic                      r_m_last;

    logic [ANGLE_W-1:0]        w_a;
    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [Z_W-1:0]     w_atan;
    logic signed [CORDIC_W-1:0] w_qx;
    logic signed [CORDIC_W-1:0] w_qy;
    logic                      w_ov_free;
    logic                      w_mv_go;
    logic                      w_issue;
    logic [DIST_W-1:0]         w_dist;
    logic [OFF_W:0]            w_next_off;
    logic                      w_last;
    logic signed [PROD_W-1:0]  w_mul_a;
    logic signed [PROD_W-1:0]  w_mul_c;
    logic signed [PROD_W-1:0]  w_mul_s;

    assign o_pop  = (r_state == S_IDLE) && !i_q_stat.empty;
    assign w_a    = i_beam.angle + ANGLE_W'(2**(ANGLE_W-3));
    assign w_dx   = r_y >>> r_iter;
    assign w_dy   = r_x >>> r_iter;
    assign w_atan = atan_lut(r_iter);

    always_comb begin
        unique case (r_quad)
            2'd1: begin
                w_qx = -r_y;
                w_qy = r_x;
            end
            2'd2: begin
                w_qx = -r_x;
                w_qy = -r_y;
            end
            2'd3: begin
                w_qx = r_y;
                w_qy = -r_x;
            end
            default: begin
                w_qx = r_x;
                w_qy = r_y;
            end
        endcase
    end

    assign w_ov_free  = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_mv_go    = r_mv && w_ov_free;
    assign w_issue    = (r_state == S_EMIT) && (!r_mv || w_ov_free);
    assign w_dist     = DIST_W'(r_range) + DIST_W'(r_off);
    assign w_next_off = (OFF_W+1)'(r_off) + (OFF_W+1)'(i_cfg.ray_step);
    assign w_last     = !((r_k < EXT_W'(MAX_EXTENSIONS)) &&
                          (w_next_off < (OFF_W+1)'(i_cfg.ray_length)));
    assign w_mul_a    = PROD_W'(signed'({1'b0, w_dist}));
    assign w_mul_c    = PROD_W'(r_cos);
    assign w_mul_s    = PROD_W'(r_sin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (r_iter == ITER_W'(CORDIC_ITERS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_issue && w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quad  <= w_a[ANGLE_W-1 -: 2];
            r_z     <= Z_W'(signed'({~w_a[ANGLE_W-3], w_a[ANGLE_W-4:0], 8'b0}));
            r_x     <= CORDIC_GAIN;
            r_y     <= '0;
            r_iter  <= '0;
            r_range <= i_beam.range;
        end else if (r_state == S_ROT) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
            r_iter <= r_iter + 1'b1;
        end
        if (r_state == S_FIN) begin
            r_cos <= round_trig(w_qx);
            r_sin <= round_trig(w_qy);
            r_k   <= '0;
            r_off <= '0;
        end else if (w_issue && !w_last) begin
            r_k   <= r_k + 1'b1;
            r_off <= w_next_off[OFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_px     <= w_mul_a * w_mul_c;
            r_py     <= w_mul_a * w_mul_s;
            r_m_ext  <= (r_k != '0);
            r_m_last <= w_last;
        end
        if (w_mv_go) begin
            o_m_axis_tdata <= {4'b0, to_coord(r_py), to_coord(r_px)};
            o_m_axis_tuser <= r_m_ext;
            o_m_axis_tlast <= r_m_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv            <= 1'b0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_mv <= 1'b1;
            end else if (w_mv_go) begin
                r_mv <= 1'b0;
            end
            if (w_mv_go) begin
                o_m_axis_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                o_m_axis_tvalid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/laser_scan_to_points_raycast_core.sv
// ----------------------------------------------------------------------------
// laser_scan_to_points_raycast_core
// Converts laser range samples to Cartesian points, with raycast extension
// points beyond each hit.
// ----------------------------------------------------------------------------
// Path: an in-window beam is queued, popped while the back end is idle, rotated by
//   the 16-step CORDIC, rounded, then registered in the multiply stage and the output
//   register. Points leave one per cycle while the output is not stalled; out-of-window
//   beams are taken one per cycle while the 4-entry beam queue has room.
// Reset (synchronous, active low): angle, queue and pipeline clear; registers
//   take their defaults (max_range 65535, ray_step 50, all others 0).
`timescale 1ns / 1ps
`default_nettype none

module laser_scan_to_points_raycast_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [15:0]                      i_s_axis_tdata,  // [15:0] range_mm
    input  wire logic                             i_s_axis_tuser,  // [0] scan_start
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [39:0]                           o_m_axis_tdata,  // [17:0] x_mm, [35:18] y_mm
    output logic                                  o_m_axis_tuser,  // [0] is_extension
    output logic                                  o_m_axis_tlast,  // last_of_beam
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lsp_pkg::*;

    t_cfg                r_cfg;
    t_q_stat             w_qstat;
    t_beam               w_push_data;
    t_beam               w_pop_data;
    logic                w_push;
    logic                w_pop;
    logic [ANGLE_W-1:0]  w_angle;
    logic                w_s_acc;

    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_angle <= '0;
            r_cfg.angle_step  <= '0;
            r_cfg.min_range   <= '0;
            r_cfg.max_range   <= 16'hFFFF;
            r_cfg.ray_step    <= RAY_W'(50);
            r_cfg.ray_length  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_ANGLE: r_cfg.start_angle <= i_cfg_data;
                CFG_ANGLE_STEP:  r_cfg.angle_step  <= i_cfg_data;
                CFG_MIN_RANGE:   r_cfg.min_range   <= i_cfg_data;
                CFG_MAX_RANGE:   r_cfg.max_range   <= i_cfg_data;
                CFG_RAY_STEP:    r_cfg.ray_step    <= i_cfg_data[RAY_W-1:0];
                CFG_RAY_LENGTH:  r_cfg.ray_length  <= i_cfg_data[RAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lsp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_stat        (w_qstat),
        .o_push          (w_push),
        .o_push_data     (w_push_data),
        .o_angle         (w_angle)
    );

    lsp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_qstat)
    );

    lsp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_stat        (w_qstat),
        .i_beam          (w_pop_data),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_angle_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && i_s_axis_tuser) |=> (w_angle == $past(r_cfg.start_angle)))
        else $error("beam angle not loaded on scan start");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= (Q_AW+1)'(Q_DEPTH))
        else $error("beam queue count beyond depth");

    a_drop_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && !w_push) |=> (w_qstat.count <= $past(w_qstat.count)))
        else $error("out-of-window beam entered the queue");

endmodule

`default_nettype wire

### dv/laser_scan_to_points_raycast_core_tb.sv
// ----------------------------------------------------------------------------
// laser_scan_to_points_raycast_core_tb
// Streams laser range samples into the point converter and checks every
// emitted point against a CORDIC-based point generator kept in the bench.
// It covers register defaults and masking, the range window, zero and long
// ray steps, all quadrants, random scans under three idling mixes, and a
// long output stall that backs up the beam intake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laser_scan_to_points_raycast_core_tb;

    localparam int RUN_LIMIT_CYCLES = 1000000;
    localparam int FLUSH_LIMIT      = 20000;
    localparam int DRAIN_CYCLES     = 64;
    localparam int HOLD_CYCLES      = 600;
    localparam int REPORT_LIMIT     = 10;
    localparam int FRAC             = lsp_pkg::TRIG_FRAC_BITS;
    localparam int ROUND_SH         = lsp_pkg::CORDIC_Q - lsp_pkg::TRIG_FRAC_BITS;
    localparam longint CORDIC_START = 652032874;
    localparam longint COORD_MAX    = 131071;
    localparam longint COORD_MIN    = -131072;
    localparam logic [lsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [lsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic               ext;
        logic               last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;  // [15:0] range_mm
    logic        i_s_axis_tuser = 1'b0;  // [0] scan_start
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;  // [17:0] x_mm, [35:18] y_mm
    logic        o_m_axis_tuser;  // [0] is_extension
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [lsp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lsp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [15:0] cfg_start_angle = 16'd0;
    logic [15:0] cfg_angle_step  = 16'd0;
    logic [15:0] cfg_min_range   = 16'd0;
    logic [15:0] cfg_max_range   = 16'd65535;
    logic [13:0] cfg_ray_step    = 14'd50;
    logic [13:0] cfg_ray_length  = 14'd0;
    logic [15:0] beam_angle      = 16'd0;

    longint atan_turns [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                163, 81};

    t_point      points_due [$];
    int          miscompares = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;

    laser_scan_to_points_raycast_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Point generator
    // ------------------------------------------------------------------------
    function automatic longint round_trig(input longint v);
        longint r;
        longint hi;
        hi = (longint'(1) <<< FRAC) - 1;
        r  = (v + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (r > hi) r = hi;
        if (r < -hi - 1) r = -hi - 1;
        return r;
    endfunction

    function automatic void beam_trig(input logic [15:0] ang, output longint cos_q,
                                      output longint sin_q);
        logic [15:0] a;
        longint x, y, z, dx, dy, t;
        a = ang + 16'd8192;
        z = (longint'(a[13:0]) - 8192) * 256;
        x = CORDIC_START;
        y = 0;
        for (int i = 0; i < lsp_pkg::CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turns[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turns[i];
            end
        end
        case (a[15:14])
            2'd1: begin
                t = x;
                x = -y;
                y = t;
            end
            2'd2: begin
                x = -x;
                y = -y;
            end
            2'd3: begin
                t = x;
                x = y;
                y = -t;
            end
            default: ;
        endcase
        cos_q = round_trig(x);
        sin_q = round_trig(y);
    endfunction

    function automatic logic signed [17:0] to_coord(input longint r, input longint t);
        longint v;
        v = (r * t + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[17:0];
    endfunction

    function automatic void expand_beam_points(input logic [15:0] rng, input logic start);
        longint c, s, r;
        int     n;
        t_point p;
        if (start) beam_angle = cfg_start_angle;
        else beam_angle = beam_angle + cfg_angle_step;
        if (!(rng > cfg_min_range && rng < cfg_max_range)) return;
        beam_trig(beam_angle, c, s);
        n = 1;
        while (n <= lsp_pkg::MAX_EXTENSIONS &&
               longint'(n) * longint'(cfg_ray_step) < longint'(cfg_ray_length)) n++;
        for (int k = 0; k < n; k++) begin
            r      = longint'(rng) + longint'(k) * longint'(cfg_ray_step);
            p.x    = to_coord(r, c);
            p.y    = to_coord(r, s);
            p.ext  = (k != 0);
            p.last = (k == n - 1);
            points_due.push_back(p);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Receiver, hold-off and point check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (hold_left == 0) && (hold_req == hold_ack) &&
                               ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (points_due.size() == 0) begin
                miscompares++;
                if (miscompares <= REPORT_LIMIT)
                    $display("unexpected point: x=%0d y=%0d ext=%0b last=%0b",
                             $signed(o_m_axis_tdata[17:0]), $signed(o_m_axis_tdata[35:18]),
                             o_m_axis_tuser, o_m_axis_tlast);
            end else begin
                want = points_due.pop_front();
                if (o_m_axis_tdata[17:0] !== want.x || o_m_axis_tdata[35:18] !== want.y ||
                    o_m_axis_tuser !== want.ext || o_m_axis_tlast !== want.last) begin
                    miscompares++;
                    if (miscompares <= REPORT_LIMIT)
                        $display("point mismatch: expected x=%0d y=%0d ext=%0b last=%0b,",
                                 want.x, want.y, want.ext, want.last,
                                 " got x=%0d y=%0d ext=%0b last=%0b",
                                 $signed(o_m_axis_tdata[17:0]),
                                 $signed(o_m_axis_tdata[35:18]),
                                 o_m_axis_tuser, o_m_axis_tlast);
                end
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request and register tasks
    // ------------------------------------------------------------------------
    task automatic send_beam(input logic [15:0] rng, input logic start);
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rng;
        i_s_axis_tuser  <= start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expand_beam_points(rng, start);
    endtask

    task automatic wait_for_idle();
        i_s_axis_tvalid <= 1'b0;
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        while (points_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [lsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lsp_pkg::CFG_START_ANGLE: cfg_start_angle = val;
            lsp_pkg::CFG_ANGLE_STEP:  cfg_angle_step  = val;
            lsp_pkg::CFG_MIN_RANGE:   cfg_min_range   = val;
            lsp_pkg::CFG_MAX_RANGE:   cfg_max_range   = val;
            lsp_pkg::CFG_RAY_STEP:    cfg_ray_step    = val[13:0];
            lsp_pkg::CFG_RAY_LENGTH:  cfg_ray_length  = val[13:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] sa, input logic [15:0] st,
                                  input logic [15:0] mn, input logic [15:0] mx,
                                  input logic [15:0] rs, input logic [15:0] rl);
        wait_for_idle();
        cfg_write(lsp_pkg::CFG_START_ANGLE, sa);
        cfg_write(lsp_pkg::CFG_ANGLE_STEP, st);
        cfg_write(lsp_pkg::CFG_MIN_RANGE, mn);
        cfg_write(lsp_pkg::CFG_MAX_RANGE, mx);
        cfg_write(lsp_pkg::CFG_RAY_STEP, rs);
        cfg_write(lsp_pkg::CFG_RAY_LENGTH, rl);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_power_on_defaults();
        send_beam(16'd0, 1'b0);
        send_beam(16'd1, 1'b0);
        send_beam(16'd65534, 1'b0);
        send_beam(16'd65535, 1'b0);
        send_beam(16'd40000, 1'b0);
    endtask

    task automatic test_register_writes();
        // zero ray step after masking, full ray length, angle wrap from the top
        apply_settings(16'hFFFF, 16'h2000, 16'd99, 16'd60001, 16'hC000, 16'hFFFF);
        cfg_write(CFG_SPARE_A, 16'h0001);
        cfg_write(CFG_SPARE_B, 16'hFFFF);
        send_beam(16'd100, 1'b1);
        send_beam(16'd99, 1'b0);
        send_beam(16'd60001, 1'b0);
        send_beam(16'd60000, 1'b0);
        send_beam(16'd32767, 1'b0);
        send_beam(16'd1, 1'b0);
        // long ray capped at the extension limit, one beam per quadrant
        apply_settings(16'h0000, 16'h4000, 16'd0, 16'd65535, 16'd1, 16'd16383);
        send_beam(16'd65534, 1'b1);
        send_beam(16'd32768, 1'b0);
        send_beam(16'd40000, 1'b0);
        send_beam(16'd1, 1'b0);
        // narrow window, ray step of 8191
        apply_settings(16'h2000, 16'hFFFF, 16'd65533, 16'd65535, 16'd8191, 16'd16383);
        send_beam(16'd65534, 1'b1);
        send_beam(16'd65535, 1'b0);
        send_beam(16'd65533, 1'b0);
    endtask

    task automatic test_random_scans(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int beams);
        int          sent;
        int          chunk_end;
        int          scan_len;
        logic [15:0] mn, mx, rs, rl, rng;
        logic        start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < beams) begin
            if ($urandom_range(2) == 0) begin
                mn = 16'd0;
                mx = 16'd65535;
            end else begin
                mn = 16'($urandom_range(3000));
                mx = 16'($urandom_range(65535, 20000));
            end
            rs = 16'($urandom_range(1) ? $urandom_range(300, 1) : $urandom_range(16383, 1));
            rl = 16'($urandom_range(1) ? $urandom_range(4000) : $urandom_range(16383));
            apply_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                           mn, mx, rs, rl);
            chunk_end = sent + 35;
            while (sent < chunk_end && sent < beams) begin
                scan_len = $urandom_range(24, 1);
                for (int j = 0; j < scan_len && sent < beams; j++) begin
                    start = (j == 0) || ($urandom_range(31) == 0);
                    if ($urandom_range(9) < 8)
                        rng = 16'($urandom_range(32'(mx) - 32'd1, 32'(mn) + 32'd1));
                    else rng = 16'($urandom_range(65535));
                    send_beam(rng, start);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_full_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(16'h0000, 16'h0800, 16'd0, 16'd65535, 16'd100, 16'd1000);
        hold_req <= ~hold_req;
        for (int j = 0; j < 24; j++)
            send_beam(16'($urandom_range(65534, 1)), j == 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 24;
        recv_idle_pct = 59;
        test_power_on_defaults();
        test_register_writes();
        test_random_scans(24, 59, 100);
        test_random_scans(59, 24, 100);
        test_random_scans(0, 0, 100);
        test_full_output_stall();
        i_s_axis_tvalid <= 1'b0;
        for (int n = 0; n < FLUSH_LIMIT && points_due.size() != 0; n++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (points_due.size() != 0) begin
            $display("%0d expected points never arrived", points_due.size());
            miscompares += points_due.size();
        end
        if (miscompares == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
